[rtl/lfo_waveform_generator_defines.svh]
// Assertion macros shared by the low-frequency oscillator RTL.
// Depends on signals named clk and rst_n in the module that expands them.
`ifndef LFO_WAVEFORM_GENERATOR_DEFINES_SVH
`define LFO_WAVEFORM_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LFO_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfo: same-cycle check failed");
`define LFO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfo: next-cycle check failed");
`else
`define LFO_ASSERT_IMPLIES(lbl, ante, cons)
`define LFO_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/lfo_pkg.sv]
// Shared types, register indexes, waveform codes and the sine table function
// for the low-frequency oscillator. No dependencies.
package lfo_pkg;

  localparam int PeriodW = 22;
  localparam int OffsetW = 16;
  localparam int AmpW    = 18;
  localparam int WaveW   = 3;
  localparam int CfgW    = 22;
  localparam int CfgIdxW = 2;
  localparam int ElapsedW = 32;
  localparam int LevelW  = 18;
  localparam int ValueW  = 17;

  localparam logic [CfgIdxW-1:0] REG_PERIOD    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_AMPLITUDE = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_WAVEFORM  = 2'd3;

  typedef enum logic [WaveW-1:0] {
    WAVE_NONE     = 3'd0,
    WAVE_SINE     = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_SAWTOOTH = 3'd3,
    WAVE_TRIANGLE = 3'd4,
    WAVE_RANDOM   = 3'd5
  } wave_t;

  localparam logic [PeriodW-1:0] PERIOD_RESET = 22'd1000;
  localparam logic [OffsetW-1:0] OFFSET_RESET = 16'd0;
  localparam logic [AmpW-1:0]    AMP_RESET    = 18'd65536;
  localparam logic [31:0]        NOISE_SEED   = 32'h2545F491;
  localparam logic [ValueW-1:0]  ONE_Q16      = 17'h10000;
  localparam logic [63:0]        HALF_PI_Q30  = 64'd1686629713;

  typedef struct packed {
    logic load;
    logic div_step;
    logic phase;
    logic lookup;
    logic wave;
    logic out_load;
  } lfo_cmd_t;

  typedef struct packed {
    logic period_zero;
  } lfo_status_t;

  // Sine of an angle given in Q30 radians, returned in Q1.16 and clamped to one.
  function automatic logic [ValueW-1:0] sine_from_x(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    sum  = (sum + 64'd8192) >> 14;
    if (sum > 64'd65536) begin
      sum = 64'd65536;
    end
    return sum[ValueW-1:0];
  endfunction

endpackage

[rtl/lfo_ctrl.sv]
// Sequencing controller for the low-frequency oscillator.
// Depends on lfo_pkg for the command and status structs.
module lfo_ctrl import lfo_pkg::*; #(
  parameter int PHASE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  lfo_status_t status,
  output lfo_cmd_t    cmd
);

  localparam int DivSteps = ElapsedW + PHASE_BITS;
  localparam int CntW     = $clog2(DivSteps);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PHASE,
    ST_LOOKUP,
    ST_WAVE,
    ST_OUT
  } state_t;

  state_t          state_r;
  logic [CntW-1:0] cnt_r;
  logic            out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.div_step = (state_r == ST_DIV);
    cmd.phase    = (state_r == ST_PHASE);
    cmd.lookup   = (state_r == ST_LOOKUP);
    cmd.wave     = (state_r == ST_WAVE);
    cmd.out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_valid && !status.period_zero) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(DivSteps - 1)) begin
            state_r <= ST_PHASE;
          end
        end
        ST_PHASE:  state_r <= ST_LOOKUP;
        ST_LOOKUP: state_r <= ST_WAVE;
        ST_WAVE:   state_r <= ST_OUT;
        ST_OUT: begin
          if (cmd.out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/lfo_datapath.sv]
// Datapath of the low-frequency oscillator: configuration registers, restoring
// divider, phase and waveform logic, sine table, noise generator and gain multiply.
// Depends on lfo_pkg.
module lfo_datapath import lfo_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_wdata,
  input  logic [ElapsedW-1:0] in_elapsed_ms,
  input  lfo_cmd_t            cmd,
  output lfo_status_t         status,
  output logic [LevelW-1:0]   out_level
);

  localparam int IdxW   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int FracW  = PHASE_BITS - 2;
  localparam int ScaleW = FracW + IdxW;

  logic [PeriodW-1:0]    period_r;
  logic [OffsetW-1:0]    offset_r;
  logic [AmpW-1:0]       amp_r;
  logic [WaveW-1:0]      wave_r;
  logic [31:0]           noise_r;
  logic [ElapsedW-1:0]   dividend_r;
  logic [PeriodW-1:0]    rem_r;
  logic [PHASE_BITS-1:0] quot_r;
  logic [PHASE_BITS-1:0] p_r;
  logic [ValueW-1:0]     sine_q_r;
  logic [ValueW-1:0]     v_r;
  logic [LevelW-1:0]     level_r;

  logic [ValueW-1:0]     sine_rom [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_from_x((HALF_PI_Q30 * 64'(g)) / SINE_TABLE_DEPTH);
  end

  logic [PeriodW:0]      trial;
  logic                  trial_ge;
  logic [PeriodW:0]      trial_diff;
  logic [PHASE_BITS-1:0] offset_scaled;
  logic [PHASE_BITS-1:0] phase_sum;
  logic [FracW-1:0]      frac;
  logic [ScaleW-1:0]     frac_scaled;
  logic [IdxW-1:0]       idx;
  logic [IdxW-1:0]       rom_addr;
  logic [15:0]           p16;
  logic [ValueW:0]       sine_sum;
  logic [31:0]           noise_nxt;
  logic [ValueW-1:0]     v_nxt;
  logic [ValueW+AmpW-1:0] product;

  assign status.period_zero = (period_r == '0);

  assign trial      = {rem_r, dividend_r[ElapsedW-1]};
  assign trial_ge   = (trial >= {1'b0, period_r});
  assign trial_diff = trial - {1'b0, period_r};

  assign offset_scaled = PHASE_BITS'({offset_r, {PHASE_BITS{1'b0}}} >> OffsetW);
  assign phase_sum     = quot_r + offset_scaled;

  assign frac        = p_r[FracW-1:0];
  assign frac_scaled = ScaleW'(frac) * ScaleW'(SINE_TABLE_DEPTH);
  assign idx         = IdxW'(frac_scaled >> FracW);
  assign rom_addr    = p_r[PHASE_BITS-2] ? IdxW'(SINE_TABLE_DEPTH) - idx : idx;

  assign p16 = 16'({p_r, 16'h0000} >> PHASE_BITS);

  assign sine_sum = p_r[PHASE_BITS-1] ? ({1'b0, ONE_Q16} - {1'b0, sine_q_r})
                                      : ({1'b0, ONE_Q16} + {1'b0, sine_q_r});

  always_comb begin
    noise_nxt = noise_r ^ (noise_r << 13);
    noise_nxt = noise_nxt ^ (noise_nxt >> 17);
    noise_nxt = noise_nxt ^ (noise_nxt << 5);
  end

  always_comb begin
    case (wave_t'(wave_r))
      WAVE_SINE:     v_nxt = sine_sum[ValueW:1];
      WAVE_SQUARE:   v_nxt = p16[15] ? '0 : ONE_Q16;
      WAVE_SAWTOOTH: v_nxt = {1'b0, p16};
      WAVE_TRIANGLE: v_nxt = p16[15] ? ((ONE_Q16 - {1'b0, p16}) << 1) : {p16, 1'b0};
      WAVE_RANDOM:   v_nxt = {1'b0, noise_nxt[31:16]};
      default:       v_nxt = '0;
    endcase
  end

  assign product = (ValueW+AmpW)'(v_r) * (ValueW+AmpW)'(amp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      offset_r <= OFFSET_RESET;
      amp_r    <= AMP_RESET;
      wave_r   <= WAVE_SINE;
      noise_r  <= NOISE_SEED;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PERIOD:    period_r <= cfg_wdata[PeriodW-1:0];
          REG_OFFSET:    offset_r <= cfg_wdata[OffsetW-1:0];
          REG_AMPLITUDE: amp_r    <= cfg_wdata[AmpW-1:0];
          REG_WAVEFORM:  wave_r   <= cfg_wdata[WaveW-1:0];
          default: ;
        endcase
      end
      if (cmd.wave && (wave_r == WAVE_RANDOM)) begin
        noise_r <= noise_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dividend_r <= in_elapsed_ms;
      rem_r      <= '0;
    end else if (cmd.div_step) begin
      dividend_r <= {dividend_r[ElapsedW-2:0], 1'b0};
      rem_r      <= trial_ge ? trial_diff[PeriodW-1:0] : trial[PeriodW-1:0];
      quot_r     <= {quot_r[PHASE_BITS-2:0], trial_ge};
    end
    if (cmd.phase) begin
      p_r <= phase_sum;
    end
    if (cmd.lookup) begin
      sine_q_r <= sine_rom[rom_addr];
    end
    if (cmd.wave) begin
      v_r <= v_nxt;
    end
    if (cmd.out_load) begin
      level_r <= product[LevelW+15:16];
    end
  end

  assign out_level = level_r;

endmodule

[rtl/lfo_waveform_generator.sv]
// Channel   | Handshake           | Payload
// input     | in_valid / in_stall   | in_elapsed_ms[31:0]
// result    | out_valid / out_stall | out_level[17:0]
// config    | cfg_we                | cfg_index[1:0], cfg_wdata[21:0]
// A new transaction is accepted only after the previous one has gone through the
// divider, phase, lookup and waveform states and its result has been loaded; the
// restoring divider produces one remainder or quotient bit per cycle.
// A zero period drops the transaction in its accept cycle with no result.
// Reset is synchronous and active low; it loads the register defaults and the noise seed.
// A stalled result waits in the output register while the next transaction starts.
`include "lfo_waveform_generator_defines.svh"
module lfo_waveform_generator import lfo_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ElapsedW-1:0] in_elapsed_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LevelW-1:0]   out_level
);

  lfo_cmd_t    cmd;
  lfo_status_t status;

  lfo_ctrl #(
    .PHASE_BITS(PHASE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lfo_datapath #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .PHASE_BITS      (PHASE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_elapsed_ms(in_elapsed_ms),
    .cmd          (cmd),
    .status       (status),
    .out_level    (out_level)
  );

  `LFO_ASSERT_IMPLIES(a_idle_quiet, !in_stall, !(cmd.div_step || cmd.phase || cmd.lookup || cmd.wave || cmd.out_load))
  `LFO_ASSERT_IMPLIES(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.div_step, cmd.phase, cmd.lookup, cmd.wave, cmd.out_load}))
  `LFO_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid)
  `LFO_ASSERT_NEXT(a_zero_drop, in_valid && !in_stall && status.period_zero, !in_stall)

endmodule
